FILE: hdl/trapezoid_move_planner_unit_macros.svh
// Assertion macros for the trapezoid move planner.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef TRAPEZOID_MOVE_PLANNER_UNIT_MACROS_SVH
`define TRAPEZOID_MOVE_PLANNER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TMPU_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tmpu same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define TMPU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tmpu next-cycle check failed");

`endif

FILE: hdl/tmpu_pkg.sv
// Shared types and constants for the trapezoid move planner.
// No dependencies.
package tmpu_pkg;

    localparam int SPEED_W   = 16;
    localparam int MAG_W     = 15;
    localparam int STEPS_W   = 16;
    localparam int DIV_W     = 24;
    localparam int GAIN_W    = 24;
    localparam int RATIO_W   = 9;
    localparam int NUM_W     = 2 * MAG_W;
    localparam int DIV_CELLS = NUM_W;
    localparam int SQ_CELLS  = MAG_W;
    localparam int SQ_REM_W  = MAG_W + 2;
    localparam int PROD_W    = GAIN_W + STEPS_W;
    localparam int SUM_W     = PROD_W + 1;

    localparam logic [SPEED_W-1:0] END_MARKER = 16'h8000;
    localparam logic [RATIO_W-1:0] RATIO_ONE  = 9'd256;

    typedef enum logic [1:0] {
        REG_START_SPEED = 2'd0,
        REG_DIVISOR     = 2'd1,
        REG_GAIN        = 2'd2,
        REG_RATIO       = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] quo;
    } div_st_t;

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [NUM_W-1:0]    x;
        logic [MAG_W-1:0]    root;
    } sq_st_t;

    typedef struct packed {
        logic               marker;
        logic               dwell;
        logic               neg;
        logic [SPEED_W-1:0] raw;
        logic [STEPS_W-1:0] steps;
        logic [STEPS_W-1:0] acc2;
        logic               sq_sat;
        logic [MAG_W-1:0]   root;
    } payload_t;

endpackage

FILE: hdl/trapezoid_move_planner_unit.sv
// Trapezoid move planner: one result per move command, one command per cycle
// unless stalled. Stages: input register, two multiply stages, 30 restoring
// divider cells (one quotient bit each) and the output register; the 15-cell
// square root chain runs alongside the divider. The whole pipe advances as one
// while the output register is empty or being taken; a held result stalls it.
// Depends on tmpu_pkg, tmpu_div_cell, tmpu_sqrt_cell and the macros header.
`include "trapezoid_move_planner_unit_macros.svh"

module trapezoid_move_planner_unit import tmpu_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration write port
    input  logic                      cfg_wr_en,
    input  logic [1:0]                cfg_index,
    input  logic [DIV_W-1:0]          cfg_wdata,
    // command channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [SPEED_W-1:0] s_cmd_speed,
    input  logic [STEPS_W-1:0]        s_cmd_steps,
    // result channel
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_keep_moving,
    output logic                      m_moving,
    output logic                      m_dir_rev,
    output logic [MAG_W-1:0]          m_launch_speed,
    output logic [STEPS_W-1:0]        m_accel_step_count,
    output logic [STEPS_W-1:0]        m_brake_start_step,
    output logic [STEPS_W-1:0]        m_brake_step_count,
    output logic signed [SPEED_W-1:0] m_cruise_speed,
    output logic                      m_speed_reduced
);
    // configuration registers
    logic [MAG_W-1:0]   start_speed_reg;
    logic [DIV_W-1:0]   divisor_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [RATIO_W-1:0] ratio_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_speed_reg <= MAG_W'(100);
            divisor_reg     <= DIV_W'(1000);
            gain_reg        <= GAIN_W'(1000);
            ratio_reg       <= RATIO_W'(128);
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_START_SPEED: start_speed_reg <= cfg_wdata[MAG_W-1:0];
                REG_DIVISOR:     divisor_reg     <= cfg_wdata[DIV_W-1:0];
                REG_GAIN:        gain_reg        <= cfg_wdata[GAIN_W-1:0];
                REG_RATIO:       ratio_reg       <= cfg_wdata[RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    // global advance: move everything while the output slot frees up
    logic m_valid_reg;
    logic en;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // stage 1: capture the transaction
    logic               v1_reg;
    logic [SPEED_W-1:0] raw1_reg;
    logic [STEPS_W-1:0] steps1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            raw1_reg   <= s_cmd_speed;
            steps1_reg <= s_cmd_steps;
        end
    end

    // stage 2: classify, square the speeds, split the steps by ratio
    logic               neg1;
    logic [SPEED_W-1:0] mag1;
    logic [RATIO_W-1:0] ratio_sat;
    logic [RATIO_W+STEPS_W-1:0] ratio_prod;

    assign neg1       = raw1_reg[SPEED_W-1];
    assign mag1       = neg1 ? SPEED_W'(-raw1_reg) : raw1_reg;
    assign ratio_sat  = (ratio_reg > RATIO_ONE) ? RATIO_ONE : ratio_reg;
    assign ratio_prod = ratio_sat * steps1_reg;

    logic             v2_reg;
    payload_t         pl2_reg;
    logic [NUM_W-1:0] mag2_reg;
    logic [NUM_W-1:0] vmin2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pl2_reg.marker <= (raw1_reg == END_MARKER);
            pl2_reg.dwell  <= (mag1 < {1'b0, start_speed_reg});
            pl2_reg.neg    <= neg1;
            pl2_reg.raw    <= raw1_reg;
            pl2_reg.steps  <= steps1_reg;
            pl2_reg.acc2   <= ratio_prod[STEPS_W+7:8];
            pl2_reg.sq_sat <= 1'b0;
            pl2_reg.root   <= '0;
            mag2_reg       <= mag1[MAG_W-1:0] * mag1[MAG_W-1:0];
            vmin2_reg      <= start_speed_reg * start_speed_reg;
        end
    end

    // stage 3: squared-speed difference feeds the divider; gain product
    // feeds the root chain
    logic [PROD_W-1:0] gx_reg;
    logic [NUM_W-1:0]  vmin2_3_reg;

    div_st_t  div_st [0:DIV_CELLS];
    sq_st_t   sq_st  [0:SQ_CELLS];
    payload_t pl_reg [0:DIV_CELLS];
    logic     vld_reg[0:DIV_CELLS];
    div_st_t  div_head_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            div_head_reg.rem <= '0;
            div_head_reg.num <= mag2_reg - vmin2_reg;
            div_head_reg.quo <= '0;
            gx_reg           <= gain_reg * pl2_reg.acc2;
            vmin2_3_reg      <= vmin2_reg;
        end
    end

    assign div_st[0] = div_head_reg;

    logic [SUM_W-1:0] sq_in;
    logic             sq_sat0;
    assign sq_in   = {{(SUM_W-NUM_W){1'b0}}, vmin2_3_reg} + {1'b0, gx_reg};
    // anything at or above 2^30 roots to 32768 or more: clamp
    assign sq_sat0 = |sq_in[SUM_W-1:NUM_W];

    assign sq_st[0].rem  = '0;
    assign sq_st[0].x    = sq_in[NUM_W-1:0];
    assign sq_st[0].root = '0;

    genvar g;
    generate
        for (g = 0; g < DIV_CELLS; g++) begin : g_div
            tmpu_div_cell u_cell (
                .aclk    (aclk),
                .en      (en),
                .divisor (divisor_reg),
                .st_in   (div_st[g]),
                .st_out  (div_st[g+1])
            );
        end
        for (g = 0; g < SQ_CELLS; g++) begin : g_sqrt
            tmpu_sqrt_cell u_cell (
                .aclk   (aclk),
                .en     (en),
                .st_in  (sq_st[g]),
                .st_out (sq_st[g+1])
            );
        end
    endgenerate

    // payload line running beside the cells; pick up the clamp flag and root
    payload_t pl_next [1:DIV_CELLS];

    always_comb begin
        for (int k = 1; k <= DIV_CELLS; k++) begin
            pl_next[k] = pl_reg[k-1];
            if (k == 1) begin
                pl_next[k].sq_sat = sq_sat0;
            end
            if (k == SQ_CELLS + 1) begin
                pl_next[k].root = sq_st[SQ_CELLS].root;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pl_reg[0] <= pl2_reg;
            for (int k = 1; k <= DIV_CELLS; k++) begin
                pl_reg[k] <= pl_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= DIV_CELLS; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= v2_reg;
            for (int k = 1; k <= DIV_CELLS; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // final decision: end marker, dwell, full ramps or shortened profile
    payload_t           pe;
    logic [NUM_W-1:0]   quo;
    logic [STEPS_W-1:0] a_sat;
    logic               fits;
    logic [MAG_W-1:0]   cm;

    assign pe    = pl_reg[DIV_CELLS];
    assign quo   = div_st[DIV_CELLS].quo;
    assign a_sat = (|quo[NUM_W-1:STEPS_W]) ? {STEPS_W{1'b1}} : quo[STEPS_W-1:0];
    assign fits  = ({1'b0, pe.steps} >= {a_sat, 1'b0});
    assign cm    = pe.sq_sat ? {MAG_W{1'b1}} : pe.root;

    logic               keep_next, moving_next, dir_next, red_next;
    logic [MAG_W-1:0]   init_next;
    logic [STEPS_W-1:0] acc_next, bstart_next, brk_next;
    logic [SPEED_W-1:0] cruise_next;

    always_comb begin
        keep_next   = 1'b0;
        moving_next = 1'b0;
        dir_next    = 1'b0;
        red_next    = 1'b0;
        init_next   = '0;
        acc_next    = '0;
        bstart_next = '0;
        brk_next    = '0;
        cruise_next = '0;
        if (!pe.marker) begin
            keep_next   = 1'b1;
            cruise_next = pe.raw;
            if (!pe.dwell) begin
                moving_next = 1'b1;
                dir_next    = pe.neg;
                init_next   = start_speed_reg;
                if (fits) begin
                    acc_next    = a_sat;
                    bstart_next = pe.steps - a_sat;
                    brk_next    = a_sat;
                end else begin
                    acc_next    = pe.acc2;
                    bstart_next = pe.acc2;
                    brk_next    = pe.steps - pe.acc2;
                    red_next    = 1'b1;
                    cruise_next = pe.neg ? SPEED_W'(-{1'b0, cm}) : {1'b0, cm};
                end
            end
        end
    end

    // output register: hold until taken
    logic               keep_reg, moving_reg, dir_reg, red_reg;
    logic [MAG_W-1:0]   init_reg;
    logic [STEPS_W-1:0] acc_reg, bstart_reg, brk_reg;
    logic [SPEED_W-1:0] cruise_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vld_reg[DIV_CELLS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            keep_reg   <= keep_next;
            moving_reg <= moving_next;
            dir_reg    <= dir_next;
            red_reg    <= red_next;
            init_reg   <= init_next;
            acc_reg    <= acc_next;
            bstart_reg <= bstart_next;
            brk_reg    <= brk_next;
            cruise_reg <= cruise_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_keep_moving       = keep_reg;
    assign m_moving            = moving_reg;
    assign m_dir_rev           = dir_reg;
    assign m_speed_reduced     = red_reg;
    assign m_launch_speed      = init_reg;
    assign m_accel_step_count  = acc_reg;
    assign m_brake_start_step  = bstart_reg;
    assign m_brake_step_count  = brk_reg;
    assign m_cruise_speed      = cruise_reg;

    // end marker clears every other field
    `TMPU_ASSERT_IMPLIES(a_marker_clear, m_valid && !m_keep_moving, !m_moving && m_cruise_speed == '0)
    // a dwell never reports a ramp or a cut speed
    `TMPU_ASSERT_IMPLIES(a_dwell_flat, m_valid && !m_moving, !m_speed_reduced && m_brake_start_step == '0 && m_accel_step_count == '0)
    // a shortened move brakes right after accelerating
    `TMPU_ASSERT_IMPLIES(a_short_split, m_valid && m_speed_reduced, m_accel_step_count == m_brake_start_step)
    // a held result stays put
    `TMPU_ASSERT_NEXT(a_hold_result, m_valid && !m_ready, m_valid && $stable(m_cruise_speed))

endmodule

FILE: hdl/tmpu_div_cell.sv
// One restoring-division cell: one quotient bit per cycle while enabled.
// Depends on tmpu_pkg.
module tmpu_div_cell import tmpu_pkg::*; (
    input  logic             aclk,
    input  logic             en,
    input  logic [DIV_W-1:0] divisor,
    input  div_st_t          st_in,
    output div_st_t          st_out
);
    logic [DIV_W:0] trial;
    logic           take;
    div_st_t        st_next;
    div_st_t        st_reg;

    always_comb begin
        trial = {st_in.rem, st_in.num[NUM_W-1]};
        take  = (trial >= {1'b0, divisor});
        st_next.num = {st_in.num[NUM_W-2:0], 1'b0};
        st_next.quo = {st_in.quo[NUM_W-2:0], take};
        if (take) begin
            st_next.rem = DIV_W'(trial - {1'b0, divisor});
        end else begin
            st_next.rem = trial[DIV_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg <= st_next;
        end
    end

    assign st_out = st_reg;
endmodule

FILE: hdl/tmpu_sqrt_cell.sv
// One digit-by-digit square root cell: one root bit per cycle while enabled.
// Depends on tmpu_pkg.
module tmpu_sqrt_cell import tmpu_pkg::*; (
    input  logic   aclk,
    input  logic   en,
    input  sq_st_t st_in,
    output sq_st_t st_out
);
    logic [SQ_REM_W+1:0] t;
    logic [SQ_REM_W+1:0] trial;
    logic                take;
    sq_st_t              st_next;
    sq_st_t              st_reg;

    always_comb begin
        t     = {st_in.rem, st_in.x[NUM_W-1 -: 2]};
        trial = {2'b00, st_in.root, 2'b01};
        take  = (t >= trial);
        st_next.x    = {st_in.x[NUM_W-3:0], 2'b00};
        st_next.root = {st_in.root[MAG_W-2:0], take};
        if (take) begin
            st_next.rem = SQ_REM_W'(t - trial);
        end else begin
            st_next.rem = t[SQ_REM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg <= st_next;
        end
    end

    assign st_out = st_reg;
endmodule

FILE: bench/trapezoid_move_planner_unit_tb.sv
// Self-checking bench for trapezoid_move_planner_unit: directed table plus random moves,
// scored against an in-bench move planner under random source and sink stalls.
// Depends on tmpu_pkg and the trapezoid_move_planner_unit RTL.
module trapezoid_move_planner_unit_tb;
    import tmpu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 34;
    localparam int WATCHDOG  = 20000;
    localparam int N_RANDOM  = 650;

    typedef struct packed {
        logic               keep_moving;
        logic               moving;
        logic               dir_rev;
        logic [MAG_W-1:0]   launch_speed;
        logic [STEPS_W-1:0] accel_steps;
        logic [STEPS_W-1:0] brake_start;
        logic [STEPS_W-1:0] brake_steps;
        logic [SPEED_W-1:0] cruise;
        logic               reduced;
    } plan_t;

    // one directed row: optional register write, then a command
    typedef struct {
        bit                 do_cfg;
        cfg_reg_t           reg_sel;
        logic [DIV_W-1:0]   reg_val;
        logic [SPEED_W-1:0] speed;
        logic [STEPS_W-1:0] steps;
        bit                 has_plan;
        plan_t              plan;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [DIV_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [SPEED_W-1:0] s_cmd_speed = '0;
    logic [STEPS_W-1:0] s_cmd_steps = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_keep_moving, m_moving, m_dir_rev, m_speed_reduced;
    logic [MAG_W-1:0] m_launch_speed;
    logic [STEPS_W-1:0] m_accel_step_count, m_brake_start_step, m_brake_step_count;
    logic signed [SPEED_W-1:0] m_cruise_speed;

    // planner's copy of the registers
    logic [MAG_W-1:0]   vmin_reg;
    logic [DIV_W-1:0]   divisor_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [RATIO_W-1:0] ratio_reg;

    plan_t plans_pending[$];
    int    mismatch_count = 0;
    int    idle_cycles = 0;
    bit    sink_hold = 1'b0;
    bit    stim_done = 1'b0;

    always #5 aclk = ~aclk;

    trapezoid_move_planner_unit dut (.*);

    function automatic logic [MAG_W-1:0] int_sqrt(input longint unsigned x);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return (root > 32767) ? 15'h7FFF : root[MAG_W-1:0];
    endfunction

    function automatic plan_t plan_move(input logic [SPEED_W-1:0] raw,
                                        input logic [STEPS_W-1:0] steps);
        plan_t p;
        bit neg;
        longint unsigned mag, vmin2, ramp, ratio, acc;
        logic [MAG_W-1:0] root;
        p = '0;
        if (raw == END_MARKER) return p;
        p.keep_moving = 1'b1;
        neg = raw[SPEED_W-1];
        mag = neg ? 64'((17'h10000 - raw) & 16'hFFFF) : 64'(raw);
        if (mag < vmin_reg) begin
            p.cruise = raw;
            return p;
        end
        vmin2 = longint'(vmin_reg) * vmin_reg;
        p.moving = 1'b1;
        p.dir_rev = neg;
        p.launch_speed = vmin_reg;
        if (divisor_reg == 0) ramp = 16'hFFFF;
        else begin
            ramp = (mag * mag - vmin2) / divisor_reg;
            if (ramp > 16'hFFFF) ramp = 16'hFFFF;
        end
        if (longint'(steps) >= 2 * ramp) begin
            p.accel_steps = STEPS_W'(ramp);
            p.brake_start = STEPS_W'(steps - ramp);
            p.brake_steps = STEPS_W'(ramp);
            p.cruise = raw;
            return p;
        end
        ratio = (ratio_reg > RATIO_ONE) ? 256 : ratio_reg;
        acc = (ratio * steps) >> 8;
        root = int_sqrt(vmin2 + longint'(gain_reg) * acc);
        p.accel_steps = STEPS_W'(acc);
        p.brake_start = STEPS_W'(acc);
        p.brake_steps = STEPS_W'(steps - acc);
        p.cruise = neg ? -{1'b0, root} : {1'b0, root};
        p.reduced = 1'b1;
        return p;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // drive one register write at the falling edge; block must be idle
    task automatic write_reg(input cfg_reg_t sel, input logic [DIV_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= val;
        @(posedge aclk);
        case (sel)
            REG_START_SPEED: vmin_reg = val[MAG_W-1:0];
            REG_DIVISOR:     divisor_reg = val;
            REG_GAIN:        gain_reg = val[GAIN_W-1:0];
            default:         ratio_reg = val[RATIO_W-1:0];
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain_pipe();
        wait (plans_pending.size() == 0);
        repeat (4) @(posedge aclk);
    endtask

    // offer one transaction; valid stays high until it is taken, and the
    // caller drops it when a gap follows
    task automatic send_cmd(input logic [SPEED_W-1:0] spd, input logic [STEPS_W-1:0] stp);
        s_valid     <= 1'b1;
        s_cmd_speed <= spd;
        s_cmd_steps <= stp;
        do @(posedge aclk); while (!s_ready);
        plans_pending.push_back(plan_move(spd, stp));
        @(negedge aclk);
    endtask

    task automatic check_expected_row(input row_t r);
        plan_t p;
        p = plan_move(r.speed, r.steps);
        if (r.has_plan && p != r.plan) begin
            report_mismatch("table row", longint'(p), longint'(r.plan));
        end
    endtask

    // random moves: mostly real speeds around vmin, some markers and dwells
    function automatic logic [SPEED_W-1:0] rand_speed();
        int unsigned pick;
        logic [SPEED_W-1:0] v;
        pick = $urandom_range(0, 19);
        if (pick == 0) return END_MARKER;
        if (pick < 3) v = SPEED_W'($urandom_range(0, vmin_reg));
        else if (pick < 6) v = SPEED_W'($urandom);
        else v = SPEED_W'($urandom_range(vmin_reg,
                                         (vmin_reg < 32000) ? vmin_reg + 600 : 32767));
        if ($urandom_range(0, 1)) v = -v;
        return v;
    endfunction

    function automatic logic [STEPS_W-1:0] rand_steps();
        case ($urandom_range(0, 3))
            0: return STEPS_W'($urandom);
            1: return STEPS_W'($urandom_range(0, 20));
            default: return STEPS_W'($urandom_range(0, 2000));
        endcase
    endfunction

    row_t table_rows[$];

    initial begin
        row_t r;
        int burst;
        // after reset: vmin 100, divisor 1000, gain 1000, ratio 128
        r = '{0, REG_START_SPEED, 0, END_MARKER, 16'hFFFF, 1, '0};
        table_rows.push_back(r);
        r = '{0, REG_START_SPEED, 0, 16'd50, 16'd7, 1,
              '{1, 0, 0, 0, 0, 0, 0, 16'd50, 0}};
        table_rows.push_back(r);
        // -50 dwell keeps the raw speed
        r = '{0, REG_START_SPEED, 0, -16'sd50, 16'd0, 1,
              '{1, 0, 0, 0, 0, 0, 0, 16'hFFCE, 0}};
        table_rows.push_back(r);
        // v = vmin: zero ramp, full cruise
        r = '{0, REG_START_SPEED, 0, 16'd100, 16'd10, 1,
              '{1, 1, 0, 15'd100, 0, 16'd10, 0, 16'd100, 0}};
        table_rows.push_back(r);
        // v = 200: ramp 30, 60 steps fit exactly
        r = '{0, REG_START_SPEED, 0, 16'd200, 16'd60, 1,
              '{1, 1, 0, 15'd100, 16'd30, 16'd30, 16'd30, 16'd200, 0}};
        table_rows.push_back(r);
        r = '{0, REG_START_SPEED, 0, 16'h7FFF, 16'hFFFF, 0, '0};
        table_rows.push_back(r);
        r = '{0, REG_START_SPEED, 0, 16'h8001, 16'd100, 0, '0};
        table_rows.push_back(r);
        r = '{0, REG_START_SPEED, 0, 16'd200, 16'd59, 0, '0};
        table_rows.push_back(r);
        r = '{1, REG_START_SPEED, 0, 16'd0, 16'd5, 0, '0};     // zero vmin: all move
        table_rows.push_back(r);
        r = '{0, REG_START_SPEED, 0, -16'sd1, 16'd3, 0, '0};
        table_rows.push_back(r);
        r = '{1, REG_DIVISOR, 0, 16'd300, 16'hFFFF, 0, '0};     // zero divisor saturates
        table_rows.push_back(r);
        r = '{1, REG_RATIO, 9'h1FF, 16'd300, 16'hFFFF, 0, '0};  // ratio above one
        table_rows.push_back(r);
        r = '{1, REG_GAIN, 24'hFFFFFF, -16'sd300, 16'hFFFF, 0, '0};
        table_rows.push_back(r);
        r = '{1, REG_START_SPEED, 15'h7FFF, 16'h7FFF, 16'd1000, 0, '0};
        table_rows.push_back(r);
        r = '{0, REG_START_SPEED, 0, 16'h7FFE, 16'd1000, 0, '0};
        table_rows.push_back(r);
        r = '{1, REG_DIVISOR, 24'hFFFFFF, 16'h8001, 16'd0, 0, '0};
        table_rows.push_back(r);
        r = '{1, REG_START_SPEED, 15'd1, 16'h7FFF, 16'd1, 0, '0};
        table_rows.push_back(r);
        r = '{1, REG_RATIO, 9'd0, 16'h7FFF, 16'd1, 0, '0};
        table_rows.push_back(r);
        r = '{1, REG_GAIN, 24'd0, -16'sd5000, 16'd3, 0, '0};
        table_rows.push_back(r);
        r = '{1, REG_DIVISOR, 24'd1, 16'd0, 16'd9, 0, '0};      // speed zero dwell at vmin 1
        table_rows.push_back(r);

        vmin_reg = 15'd100;
        divisor_reg = 24'd1000;
        gain_reg = 24'd1000;
        ratio_reg = 9'd128;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table, one transaction per row
        foreach (table_rows[i]) begin
            if (table_rows[i].do_cfg) begin
                s_valid <= 1'b0;
                drain_pipe();
                write_reg(table_rows[i].reg_sel, table_rows[i].reg_val);
            end
            check_expected_row(table_rows[i]);
            send_cmd(table_rows[i].speed, table_rows[i].steps);
        end

        // random phases, each under a new register setting
        for (int ph = 0; ph < 5; ph++) begin
            s_valid <= 1'b0;
            drain_pipe();
            write_reg(REG_START_SPEED,
                      (ph == 0) ? DIV_W'(100) : DIV_W'($urandom_range(0, 4000)));
            write_reg(REG_DIVISOR,
                      (ph == 1) ? DIV_W'(0) : DIV_W'($urandom_range(1, 3000)));
            write_reg(REG_GAIN,
                      (ph == 2) ? DIV_W'(24'hFFFFFF) : DIV_W'($urandom_range(0, 40000)));
            write_reg(REG_RATIO,
                      (ph == 3) ? DIV_W'(9'h1FF) : DIV_W'($urandom_range(0, 256)));
            if (ph == 4) sink_hold = 1'b1;   // long sink stall while source keeps offering
            for (int n = 0; n < N_RANDOM / 5; ) begin
                burst = $urandom_range(1, 24);
                for (int b = 0; b < burst && n < N_RANDOM / 5; b++, n++)
                    send_cmd(rand_speed(), rand_steps());
                if ($urandom_range(0, 3) == 0) begin
                    s_valid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(negedge aclk);
                end
            end
            if (ph == 2) begin
                s_valid <= 1'b0;             // source waits for every result
                drain_pipe();
            end
        end
        s_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // sink: random stall pattern, plus one long hold-off on request
    initial begin
        int run;
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold && !hold_done) begin
                m_ready <= 1'b0;
                repeat (300) @(negedge aclk);
                hold_done = 1'b1;
            end
            run = $urandom_range(1, 16);
            if ($urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat (run) @(negedge aclk);
            end
            m_ready <= 1'b1;
            repeat (run) @(negedge aclk);
        end
    end

    // score each result transaction against the oldest plan
    always @(posedge aclk) begin
        plan_t want;
        if (aresetn && m_valid && m_ready) begin
            if (plans_pending.size() == 0) begin
                report_mismatch("result with no command outstanding", 0, 0);
            end else begin
                want = plans_pending.pop_front();
                if (m_keep_moving !== want.keep_moving)
                    report_mismatch("keep_moving", m_keep_moving, want.keep_moving);
                if (m_moving !== want.moving)
                    report_mismatch("moving", m_moving, want.moving);
                if (m_dir_rev !== want.dir_rev)
                    report_mismatch("dir_rev", m_dir_rev, want.dir_rev);
                if (m_launch_speed !== want.launch_speed)
                    report_mismatch("launch_speed", m_launch_speed, want.launch_speed);
                if (m_accel_step_count !== want.accel_steps)
                    report_mismatch("accel_step_count", m_accel_step_count, want.accel_steps);
                if (m_brake_start_step !== want.brake_start)
                    report_mismatch("brake_start_step", m_brake_start_step, want.brake_start);
                if (m_brake_step_count !== want.brake_steps)
                    report_mismatch("brake_step_count", m_brake_step_count, want.brake_steps);
                if (m_cruise_speed !== want.cruise)
                    report_mismatch("cruise_speed", m_cruise_speed, want.cruise);
                if (m_speed_reduced !== want.reduced)
                    report_mismatch("speed_reduced", m_speed_reduced, want.reduced);
            end
        end
    end

    // watchdog: count cycles with no transaction on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("trapezoid_move_planner_unit_tb: FAIL");
            $finish;
        end
    end

    // end of run: drain, then allow the pipeline latency for strays
    initial begin
        wait (stim_done);
        wait (plans_pending.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        if (mismatch_count == 0 && plans_pending.size() == 0) begin
            $display("trapezoid_move_planner_unit_tb: PASS");
        end else begin
            $display("trapezoid_move_planner_unit_tb: FAIL");
        end
        $finish;
    end
endmodule

FILE: trapezoid_move_planner_unit.f
+incdir+hdl
hdl/tmpu_pkg.sv
hdl/tmpu_div_cell.sv
hdl/tmpu_sqrt_cell.sv
hdl/trapezoid_move_planner_unit.sv
bench/trapezoid_move_planner_unit_tb.sv
